>>> rtl/mgsp_pkg.sv
package mgsp_pkg;

   localparam int DATA_W = 32;

   // operation codes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_NUM_VECTORS   = 2'd0;
   localparam logic [1:0] CSR_USED_LENGTH   = 2'd1;
   localparam logic [1:0] CSR_PADDED_LENGTH = 2'd2;
   localparam logic [1:0] CSR_NORM_FLOOR    = 2'd3;

   typedef struct packed {
      logic [1:0]               operation;
      logic [3:0]               vector_index;
      logic [7:0]               element_index;
      logic signed [DATA_W-1:0] psi_real_in;
      logic signed [DATA_W-1:0] psi_imag_in;
      logic signed [DATA_W-1:0] hpsi_real_in;
      logic signed [DATA_W-1:0] hpsi_imag_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] psi_real_out;
      logic signed [DATA_W-1:0] psi_imag_out;
      logic signed [DATA_W-1:0] hpsi_real_out;
      logic signed [DATA_W-1:0] hpsi_imag_out;
      logic                     run_status;
      logic [3:0]               failed_vector;
   } rsp_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } cval_type;

   // norm and reciprocal handed back by the reciprocal unit
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] norm;
      logic [DATA_W-1:0] inv;
   } recip_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

>>> rtl/mgsp_recip.sv
module mgsp_recip #(
   parameter int FRACTION_BITS = 28
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [30:0]         square,
   output mgsp_pkg::recip_type result
);
   import mgsp_pkg::*;

   localparam int DW = 2 * FRACTION_BITS + 1;
   localparam int SW = $clog2(DW + 1);

   typedef enum logic [1:0] {PH_IDLE, PH_SQRT, PH_DIV} phase_type;

   phase_type     phase_ff;
   logic [63:0]   rem_ff, res_ff, bit_ff;
   logic [SW-1:0] step_ff;
   logic [32:0]   drem_ff;
   logic [DW-1:0] quo_ff;
   logic          done_ff;

   logic [63:0] trial;
   logic        take;
   logic [32:0] shifted;
   logic        dtake;

   // one root bit per cycle, then one quotient bit per cycle
   assign trial   = res_ff + bit_ff;
   assign take    = rem_ff >= trial;
   assign shifted = {drem_ff[31:0], (step_ff == '0)};
   assign dtake   = shifted >= {1'b0, res_ff[31:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            PH_IDLE: begin
               if (start) begin
                  rem_ff   <= 64'(square) << FRACTION_BITS;
                  res_ff   <= '0;
                  bit_ff   <= 64'h4000_0000_0000_0000;
                  phase_ff <= PH_SQRT;
               end
            end
            PH_SQRT: begin
               if (take) begin
                  rem_ff <= rem_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  step_ff  <= '0;
                  drem_ff  <= '0;
                  phase_ff <= PH_DIV;
               end
            end
            PH_DIV: begin
               drem_ff <= dtake ? shifted - {1'b0, res_ff[31:0]} : shifted;
               quo_ff  <= {quo_ff[DW-2:0], dtake};
               step_ff <= step_ff + 1'b1;
               if (step_ff == SW'(DW - 1)) begin
                  done_ff  <= 1'b1;
                  phase_ff <= PH_IDLE;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign result.done = done_ff;
   assign result.norm = res_ff[31:0];
   assign result.inv  = (|quo_ff[DW-1:31]) ? 32'h7fff_ffff : {1'b0, quo_ff[30:0]};

endmodule

>>> rtl/modified_gram_schmidt_pair.sv
// Modified Gram-Schmidt over a pair of complex vector stores (psi and H-psi).
// Request channel (req_valid / req_stall / req_data) carries one beat per item:
// load writes one element pair, read returns one element pair plus the status
// of the last run, run orthonormalizes vectors 0..num_vectors-1 in place.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns one beat for each
// read and each run; loads and unknown operations return nothing.
// Loads are taken one per cycle while no run is active. Reads are taken one per
// cycle while no run is active and the read stage can drain, and answer through
// the registered read port of the stores and the read stage. A run holds
// req_stall high until its response is loaded; every pass streams one element
// per cycle through the memory read port and a read, multiply and write-back
// pipeline, and the norm reciprocal comes from a bit-serial root and divide
// unit. A failing norm ends the run early. Inner product, subtract and norm
// passes cover the used length, the scale pass the larger of used and padded.
// Reset clears the control state, the status and the configuration to its
// defaults; store contents are undefined until loaded, no clearing pass.
// While rsp_stall is high the response holds; one further read may sit in the
// read stage behind it, then reads and runs stall. csr writes land at once.
module modified_gram_schmidt_pair #(
   parameter int MAX_VECTORS   = 16,
   parameter int MAX_LENGTH    = 256,
   parameter int FRACTION_BITS = 28
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mgsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mgsp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import mgsp_pkg::*;

   localparam int DEPTH = MAX_VECTORS * MAX_LENGTH;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int EW    = MAX_LENGTH > 1 ? $clog2(MAX_LENGTH) : 1;
   localparam int CLW   = $clog2(MAX_LENGTH + 1);
   localparam int CVW   = $clog2(MAX_VECTORS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_VEC, ST_INNER, ST_SUB, ST_NORM, ST_RECIP, ST_SCALE, ST_DONE
   } state_type;

   typedef enum logic [1:0] {MODE_INNER, MODE_SUB, MODE_SCALE} mode_type;

   function automatic logic [AW-1:0] addr_of(input int v, input int e);
      return AW'(v * MAX_LENGTH + e);
   endfunction

   // configuration
   logic [4:0]  num_vectors_ff;
   logic [8:0]  used_length_ff, padded_length_ff;
   logic [30:0] norm_floor_ff;

   // stores and their read registers
   cval_type psi_mem  [DEPTH];
   cval_type hpsi_mem [DEPTH];
   cval_type psi_a_ff, psi_b_ff, hpsi_a_ff, hpsi_b_ff;

   // sequencer
   state_type        state_ff;
   logic [CVW-1:0]   ib_ff, jb_ff;
   logic [CLW-1:0]   i_ff;
   logic signed [63:0] acc_re_ff, acc_im_ff;
   logic signed [31:0] c_re_ff, c_im_ff, inv_ff;
   logic             last_status_ff;
   logic [3:0]       last_failed_ff;
   logic             recip_start_ff;
   logic [30:0]      recip_sq_ff;
   recip_type        recip;

   // element pipeline
   logic             d_vld_ff, p_vld_ff;
   mode_type         d_mode_ff, p_mode_ff;
   logic [EW-1:0]    d_elem_ff, p_elem_ff;
   logic             d_zero_ff, p_zero_ff;
   logic signed [63:0] p_ff [8];
   cval_type         p_y_psi_ff, p_y_hpsi_ff;

   // read response stage and output register
   logic    s1_valid_ff, s1_zero_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [CLW-1:0] n_len, scale_len, pass_count;
   logic [CVW-1:0] nv;
   logic           req_ok, req_acc, load_acc, read_acc, run_acc;
   logic [AW-1:0]  req_addr, ra, rb, wa;
   logic           idle, out_free, s1_adv, issuing, pass_done, rd_en, we;
   mode_type       iss_mode;
   cval_type       psi_wd, hpsi_wd;
   logic signed [31:0] opa [8];
   logic signed [31:0] opb [8];
   logic signed [63:0] f [8];
   logic signed [31:0] n2;
   logic [CVW+3:0] ib_wide;

   // clamp the configured lengths and counts to what the stores hold
   always_comb begin
      int n, p, v;
      n = int'(used_length_ff) > MAX_LENGTH ? MAX_LENGTH : int'(used_length_ff);
      p = int'(padded_length_ff) > MAX_LENGTH ? MAX_LENGTH : int'(padded_length_ff);
      v = int'(num_vectors_ff) > MAX_VECTORS ? MAX_VECTORS : int'(num_vectors_ff);
      n_len     = CLW'(n);
      scale_len = CLW'(p > n ? p : n);
      nv        = CVW'(v);
   end

   assign req_ok   = (int'(req_data.vector_index) < MAX_VECTORS)
                   && (int'(req_data.element_index) < MAX_LENGTH);
   assign req_addr = addr_of(int'(req_data.vector_index), int'(req_data.element_index));

   assign idle     = state_ff == ST_IDLE;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;

   // hold reads while the read stage cannot drain; hold runs until it is empty
   assign req_stall = !idle
                    || (req_data.operation == OP_READ && s1_valid_ff && !out_free)
                    || (req_data.operation == OP_RUN && s1_valid_ff);
   assign req_acc  = req_valid && !req_stall;
   assign load_acc = req_acc && req_data.operation == OP_LOAD && req_ok;
   assign read_acc = req_acc && req_data.operation == OP_READ;
   assign run_acc  = req_acc && req_data.operation == OP_RUN;

   assign csr_ready = 1'b1;

   always_comb begin
      unique case (state_ff)
         ST_SUB:   iss_mode = MODE_SUB;
         ST_SCALE: iss_mode = MODE_SCALE;
         default:  iss_mode = MODE_INNER;
      endcase
   end

   assign pass_count = (state_ff == ST_SCALE) ? scale_len : n_len;
   assign issuing    = (state_ff == ST_INNER || state_ff == ST_SUB
                     || state_ff == ST_NORM || state_ff == ST_SCALE) && (i_ff < pass_count);
   assign pass_done  = (i_ff >= pass_count) && !d_vld_ff && !p_vld_ff;

   assign ra    = addr_of(int'(state_ff == ST_NORM ? ib_ff : jb_ff), int'(i_ff));
   assign rb    = idle ? req_addr : addr_of(int'(ib_ff), int'(i_ff));
   assign rd_en = read_acc || issuing;

   // operand selection ahead of the multiplier row
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         opa[k] = '0;
         opb[k] = '0;
      end
      unique case (d_mode_ff)
         MODE_INNER: begin
            opa[0] = psi_a_ff.re; opb[0] = psi_b_ff.re;
            opa[1] = psi_a_ff.im; opb[1] = psi_b_ff.im;
            opa[2] = psi_a_ff.re; opb[2] = psi_b_ff.im;
            opa[3] = psi_a_ff.im; opb[3] = psi_b_ff.re;
         end
         MODE_SUB: begin
            opa[0] = c_re_ff; opb[0] = psi_a_ff.re;
            opa[1] = c_im_ff; opb[1] = psi_a_ff.im;
            opa[2] = c_re_ff; opb[2] = psi_a_ff.im;
            opa[3] = c_im_ff; opb[3] = psi_a_ff.re;
            opa[4] = c_re_ff; opb[4] = hpsi_a_ff.re;
            opa[5] = c_im_ff; opb[5] = hpsi_a_ff.im;
            opa[6] = c_re_ff; opb[6] = hpsi_a_ff.im;
            opa[7] = c_im_ff; opb[7] = hpsi_a_ff.re;
         end
         MODE_SCALE: begin
            opa[0] = psi_b_ff.re;  opb[0] = inv_ff;
            opa[1] = psi_b_ff.im;  opb[1] = inv_ff;
            opa[4] = hpsi_b_ff.re; opb[4] = inv_ff;
            opa[5] = hpsi_b_ff.im; opb[5] = inv_ff;
         end
         default: ;
      endcase
   end

   // floored products and the write-back values
   always_comb begin
      logic signed [63:0] y_re, y_im, hy_re, hy_im;
      y_re  = p_y_psi_ff.re;
      y_im  = p_y_psi_ff.im;
      hy_re = p_y_hpsi_ff.re;
      hy_im = p_y_hpsi_ff.im;
      for (int k = 0; k < 8; k++) begin
         f[k] = p_ff[k] >>> FRACTION_BITS;
      end
      if (p_mode_ff == MODE_SUB) begin
         psi_wd.re  = sat32(y_re - (f[0] - f[1]));
         psi_wd.im  = sat32(y_im - (f[2] + f[3]));
         hpsi_wd.re = sat32(hy_re - (f[4] - f[5]));
         hpsi_wd.im = sat32(hy_im - (f[6] + f[7]));
      end else if (p_zero_ff) begin
         psi_wd  = '0;
         hpsi_wd = '0;
      end else begin
         psi_wd.re  = sat32(f[0]);
         psi_wd.im  = sat32(f[1]);
         hpsi_wd.re = sat32(f[4]);
         hpsi_wd.im = sat32(f[5]);
      end
   end

   assign we = load_acc || (p_vld_ff && p_mode_ff != MODE_INNER);
   assign wa = load_acc ? req_addr : addr_of(int'(ib_ff), int'(p_elem_ff));

   // stores: one write port, two registered read ports each
   always_ff @(posedge clock) begin
      if (we) begin
         if (load_acc) begin
            psi_mem[wa]  <= '{re: req_data.psi_real_in,  im: req_data.psi_imag_in};
            hpsi_mem[wa] <= '{re: req_data.hpsi_real_in, im: req_data.hpsi_imag_in};
         end else begin
            psi_mem[wa]  <= psi_wd;
            hpsi_mem[wa] <= hpsi_wd;
         end
      end
      if (rd_en) begin
         psi_a_ff  <= psi_mem[ra];
         hpsi_a_ff <= hpsi_mem[ra];
         psi_b_ff  <= psi_mem[rb];
         hpsi_b_ff <= hpsi_mem[rb];
      end
   end

   // element pipeline: read, multiply, write back or accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= issuing;
         p_vld_ff <= d_vld_ff;
      end
      d_mode_ff   <= iss_mode;
      d_elem_ff   <= i_ff[EW-1:0];
      d_zero_ff   <= i_ff >= n_len;
      p_mode_ff   <= d_mode_ff;
      p_elem_ff   <= d_elem_ff;
      p_zero_ff   <= d_zero_ff;
      p_y_psi_ff  <= psi_b_ff;
      p_y_hpsi_ff <= hpsi_b_ff;
      for (int k = 0; k < 8; k++) begin
         p_ff[k] <= opa[k] * opb[k];
      end
   end

   assign n2      = sat32(acc_re_ff);
   assign ib_wide = {4'b0, ib_ff};

   mgsp_recip #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_recip (
      .clock  (clock),
      .reset  (reset),
      .start  (recip_start_ff),
      .square (recip_sq_ff),
      .result (recip)
   );

   // sequencer, status, configuration and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         last_status_ff   <= 1'b0;
         last_failed_ff   <= '0;
         recip_start_ff   <= 1'b0;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         num_vectors_ff   <= 5'd16;
         used_length_ff   <= 9'd256;
         padded_length_ff <= 9'd256;
         norm_floor_ff    <= '0;
      end else begin
         recip_start_ff <= 1'b0;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_NUM_VECTORS:   num_vectors_ff   <= csr_data[4:0];
               CSR_USED_LENGTH:   used_length_ff   <= csr_data[8:0];
               CSR_PADDED_LENGTH: padded_length_ff <= csr_data[8:0];
               CSR_NORM_FLOOR:    norm_floor_ff    <= csr_data[30:0];
               default: ;
            endcase
         end

         if (issuing) begin
            i_ff <= i_ff + 1'b1;
         end
         if (p_vld_ff && p_mode_ff == MODE_INNER) begin
            acc_re_ff <= acc_re_ff + f[0] + f[1];
            acc_im_ff <= acc_im_ff + f[2] - f[3];
         end

         // read stage
         if (read_acc) begin
            s1_valid_ff <= 1'b1;
            s1_zero_ff  <= !req_ok;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end

         // response register
         if (out_free) begin
            priority if (s1_adv) begin
               rsp_valid_ff               <= 1'b1;
               rsp_data_ff.psi_real_out   <= s1_zero_ff ? '0 : psi_b_ff.re;
               rsp_data_ff.psi_imag_out   <= s1_zero_ff ? '0 : psi_b_ff.im;
               rsp_data_ff.hpsi_real_out  <= s1_zero_ff ? '0 : hpsi_b_ff.re;
               rsp_data_ff.hpsi_imag_out  <= s1_zero_ff ? '0 : hpsi_b_ff.im;
               rsp_data_ff.run_status     <= last_status_ff;
               rsp_data_ff.failed_vector  <= last_failed_ff;
            end else if (state_ff == ST_DONE) begin
               rsp_valid_ff               <= 1'b1;
               rsp_data_ff.psi_real_out   <= '0;
               rsp_data_ff.psi_imag_out   <= '0;
               rsp_data_ff.hpsi_real_out  <= '0;
               rsp_data_ff.hpsi_imag_out  <= '0;
               rsp_data_ff.run_status     <= last_status_ff;
               rsp_data_ff.failed_vector  <= last_failed_ff;
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (run_acc) begin
                  last_status_ff <= 1'b0;
                  last_failed_ff <= '0;
                  ib_ff          <= '0;
                  state_ff       <= ST_VEC;
               end
            end
            ST_VEC: begin
               // start the next vector, or finish
               jb_ff     <= '0;
               i_ff      <= '0;
               acc_re_ff <= '0;
               acc_im_ff <= '0;
               if (ib_ff >= nv) begin
                  state_ff <= ST_DONE;
               end else if (ib_ff == '0) begin
                  state_ff <= ST_NORM;
               end else begin
                  state_ff <= ST_INNER;
               end
            end
            ST_INNER: begin
               if (pass_done) begin
                  c_re_ff  <= sat32(acc_re_ff);
                  c_im_ff  <= sat32(acc_im_ff);
                  i_ff     <= '0;
                  state_ff <= ST_SUB;
               end
            end
            ST_SUB: begin
               if (pass_done) begin
                  jb_ff     <= jb_ff + 1'b1;
                  i_ff      <= '0;
                  acc_re_ff <= '0;
                  acc_im_ff <= '0;
                  state_ff  <= (jb_ff + 1'b1 == ib_ff) ? ST_NORM : ST_INNER;
               end
            end
            ST_NORM: begin
               if (pass_done) begin
                  recip_sq_ff    <= n2[31] ? '0 : n2[30:0];
                  recip_start_ff <= 1'b1;
                  state_ff       <= ST_RECIP;
               end
            end
            ST_RECIP: begin
               if (recip.done) begin
                  if (recip.norm <= {1'b0, norm_floor_ff}) begin
                     // dependent vector: stop with it unscaled
                     last_status_ff <= 1'b1;
                     last_failed_ff <= ib_wide[3:0];
                     state_ff       <= ST_DONE;
                  end else begin
                     inv_ff   <= recip.inv;
                     i_ff     <= '0;
                     state_ff <= ST_SCALE;
                  end
               end
            end
            ST_SCALE: begin
               if (pass_done) begin
                  ib_ff    <= ib_ff + 1'b1;
                  state_ff <= ST_VEC;
               end
            end
            ST_DONE: begin
               if (out_free && !s1_valid_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/mgsp_checker.sv
module mgsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mgsp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mgsp_pkg::rsp_type rsp_data
);
   import mgsp_pkg::*;

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped under stall");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed under stall");

   // a successful status never names a failing vector
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.run_status |-> rsp_data.failed_vector == 4'd0)
      else $error("failed vector set with success status");

   // an accepted run occupies the block on the next cycle
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.operation == OP_RUN |=> req_stall)
      else $error("request taken right after a run");

endmodule

bind modified_gram_schmidt_pair mgsp_checker u_mgsp_checker (.*);
